// ===== rtl/char_lcd_nibble_sequencer_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the character LCD nibble sequencer
// Both macros sample on the rising edge of clk and are held off during reset.
// ---------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH

// Same-cycle implication
`define LCDSEQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LCDSEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lcdseq_pkg.sv =====
// ---------------------------------------------------------------------------
// lcdseq_pkg
// Types, constants and the microcode program of the LCD nibble sequencer.
// ---------------------------------------------------------------------------
package lcdseq_pkg;

  // Default display width in columns
  localparam int unsigned COLUMNS_DEF = 16;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_INIT   = 2'd0,
    KIND_CMD    = 2'd1,
    KIND_CHAR   = 2'd2,
    KIND_CURSOR = 2'd3
  } kind_t;

  // Register indexes on the configuration port
  localparam int unsigned     REG_IDX_W      = 3;
  localparam logic [2:0]      REG_BUS_WIDTH_8 = 3'd0;
  localparam logic [2:0]      REG_TWO_LINES   = 3'd1;
  localparam logic [2:0]      REG_LARGE_FONT  = 3'd2;
  localparam logic [2:0]      REG_SHORT_HOLD  = 3'd3;
  localparam logic [2:0]      REG_LONG_HOLD   = 3'd4;

  localparam int unsigned HOLD_W       = 24;
  localparam logic [23:0] SHORT_HOLD_RST = 24'd50000;
  localparam logic [23:0] LONG_HOLD_RST  = 24'd500000;
  localparam logic [23:0] CLEAR_SETTLE   = 24'd10;

  // Cursor bases
  localparam logic [7:0] ROW1_BASE = 8'h80;
  localparam logic [7:0] ROW2_BASE = 8'hC0;

  // Configuration seen by the datapath
  typedef struct packed {
    logic              bus_width_8;
    logic              two_lines;
    logic              large_font;
    logic [23:0]       short_hold;
    logic [23:0]       long_hold;
  } cfg_t;

  // Nibble source
  typedef enum logic [1:0] {
    NS_IMM = 2'd0,
    NS_HI  = 2'd1,
    NS_LO  = 2'd2
  } nsel_t;

  // Byte source
  typedef enum logic [1:0] {
    BS_IMM  = 2'd0,
    BS_REQ  = 2'd1,
    BS_FSET = 2'd2
  } bsel_t;

  // Hold source
  typedef enum logic [1:0] {
    HS_SHORT  = 2'd0,
    HS_LONG   = 2'd1,
    HS_SETTLE = 2'd2
  } hsel_t;

  // One control word per phase
  typedef struct packed {
    logic       en;
    nsel_t      nsel;
    bsel_t      bsel;
    logic [7:0] imm;
    hsel_t      hsel;
    logic       last;
  } ucode_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic   accept;
    logic   step;
    ucode_t word;
  } seq_ctl_t;

  // Program layout
  localparam int unsigned PC_W     = 6;
  localparam logic [5:0]  PC_INIT  = 6'd0;
  localparam logic [5:0]  PC_BYTE  = 6'd29;
  localparam logic [5:0]  PROG_LEN = 6'd33;

  function automatic ucode_t mk(input logic en, input nsel_t nsel, input bsel_t bsel,
                                input logic [7:0] imm, input hsel_t hsel,
                                input logic last);
    ucode_t w;
    w.en   = en;
    w.nsel = nsel;
    w.bsel = bsel;
    w.imm  = imm;
    w.hsel = hsel;
    w.last = last;
    return w;
  endfunction

  // Microcode program: init from PC_INIT, single byte from PC_BYTE
  function automatic ucode_t ucode_rom(input logic [5:0] pc);
    ucode_t w;
    case (pc)
      // power-up wait
      6'd0:  w = mk(1'b0, NS_IMM, BS_IMM, 8'h00, HS_SHORT, 1'b0);
      // wake-up nibbles 3, 3, 3 then 2
      6'd1:  w = mk(1'b1, NS_IMM, BS_IMM, 8'h03, HS_SHORT, 1'b0);
      6'd2:  w = mk(1'b0, NS_IMM, BS_IMM, 8'h03, HS_SHORT, 1'b0);
      6'd3:  w = mk(1'b1, NS_IMM, BS_IMM, 8'h03, HS_SHORT, 1'b0);
      6'd4:  w = mk(1'b0, NS_IMM, BS_IMM, 8'h03, HS_SHORT, 1'b0);
      6'd5:  w = mk(1'b1, NS_IMM, BS_IMM, 8'h03, HS_SHORT, 1'b0);
      6'd6:  w = mk(1'b0, NS_IMM, BS_IMM, 8'h03, HS_SHORT, 1'b0);
      6'd7:  w = mk(1'b1, NS_IMM, BS_IMM, 8'h02, HS_LONG,  1'b0);
      6'd8:  w = mk(1'b0, NS_IMM, BS_IMM, 8'h02, HS_SHORT, 1'b0);
      // display on, cursor off
      6'd9:  w = mk(1'b1, NS_HI, BS_IMM, 8'h0C, HS_SHORT, 1'b0);
      6'd10: w = mk(1'b0, NS_HI, BS_IMM, 8'h0C, HS_SHORT, 1'b0);
      6'd11: w = mk(1'b1, NS_LO, BS_IMM, 8'h0C, HS_SHORT, 1'b0);
      6'd12: w = mk(1'b0, NS_LO, BS_IMM, 8'h0C, HS_SHORT, 1'b0);
      // entry mode
      6'd13: w = mk(1'b1, NS_HI, BS_IMM, 8'h04, HS_SHORT, 1'b0);
      6'd14: w = mk(1'b0, NS_HI, BS_IMM, 8'h04, HS_SHORT, 1'b0);
      6'd15: w = mk(1'b1, NS_LO, BS_IMM, 8'h04, HS_SHORT, 1'b0);
      6'd16: w = mk(1'b0, NS_LO, BS_IMM, 8'h04, HS_SHORT, 1'b0);
      // cursor shift
      6'd17: w = mk(1'b1, NS_HI, BS_IMM, 8'h10, HS_SHORT, 1'b0);
      6'd18: w = mk(1'b0, NS_HI, BS_IMM, 8'h10, HS_SHORT, 1'b0);
      6'd19: w = mk(1'b1, NS_LO, BS_IMM, 8'h10, HS_SHORT, 1'b0);
      6'd20: w = mk(1'b0, NS_LO, BS_IMM, 8'h10, HS_SHORT, 1'b0);
      // clear display, with settle time on the tail
      6'd21: w = mk(1'b1, NS_HI, BS_IMM, 8'h01, HS_SHORT,  1'b0);
      6'd22: w = mk(1'b0, NS_HI, BS_IMM, 8'h01, HS_SHORT,  1'b0);
      6'd23: w = mk(1'b1, NS_LO, BS_IMM, 8'h01, HS_SHORT,  1'b0);
      6'd24: w = mk(1'b0, NS_LO, BS_IMM, 8'h01, HS_SETTLE, 1'b0);
      // function set from configuration
      6'd25: w = mk(1'b1, NS_HI, BS_FSET, 8'h00, HS_SHORT, 1'b0);
      6'd26: w = mk(1'b0, NS_HI, BS_FSET, 8'h00, HS_SHORT, 1'b0);
      6'd27: w = mk(1'b1, NS_LO, BS_FSET, 8'h00, HS_SHORT, 1'b0);
      6'd28: w = mk(1'b0, NS_LO, BS_FSET, 8'h00, HS_SHORT, 1'b1);
      // single request byte
      6'd29: w = mk(1'b1, NS_HI, BS_REQ, 8'h00, HS_SHORT, 1'b0);
      6'd30: w = mk(1'b0, NS_HI, BS_REQ, 8'h00, HS_SHORT, 1'b0);
      6'd31: w = mk(1'b1, NS_LO, BS_REQ, 8'h00, HS_SHORT, 1'b0);
      6'd32: w = mk(1'b0, NS_LO, BS_REQ, 8'h00, HS_SHORT, 1'b1);
      default: w = mk(1'b0, NS_IMM, BS_IMM, 8'h00, HS_SHORT, 1'b1);
    endcase
    return w;
  endfunction

  // Column offset table: entry c is (c - 1) wrapped into 0 .. cols-1
  function automatic logic [127:0][7:0] off_table(input int unsigned cols);
    logic [127:0][7:0] t;
    logic [7:0]        off;
    logic [7:0]        top;
    top = 8'(cols - 1);
    off = top;
    for (int i = 0; i < 128; i++) begin
      t[i] = off;
      if (off == top) begin
        off = 8'd0;
      end else begin
        off = off + 8'd1;
      end
    end
    return t;
  endfunction

endpackage

// ===== rtl/lcdseq_cfg.sv =====
// ---------------------------------------------------------------------------
// lcdseq_cfg
// APB register bank holding the function-set bits and the hold times.
// ---------------------------------------------------------------------------
module lcdseq_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output lcdseq_pkg::cfg_t  cfg
);
  import lcdseq_pkg::*;

  logic        bus_width_8_r;
  logic        two_lines_r;
  logic        large_font_r;
  logic [23:0] short_hold_r;
  logic [23:0] long_hold_r;
  logic [2:0]  idx;
  logic        wr;

  assign idx        = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite;

  // Register writes on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_width_8_r <= 1'b0;
      two_lines_r   <= 1'b1;
      large_font_r  <= 1'b0;
      short_hold_r  <= SHORT_HOLD_RST;
      long_hold_r   <= LONG_HOLD_RST;
    end else if (wr) begin
      case (idx)
        REG_BUS_WIDTH_8: bus_width_8_r <= cfg_pwdata[0];
        REG_TWO_LINES:   two_lines_r   <= cfg_pwdata[0];
        REG_LARGE_FONT:  large_font_r  <= cfg_pwdata[0];
        REG_SHORT_HOLD:  short_hold_r  <= cfg_pwdata[23:0];
        REG_LONG_HOLD:   long_hold_r   <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_BUS_WIDTH_8: cfg_prdata = {31'd0, bus_width_8_r};
      REG_TWO_LINES:   cfg_prdata = {31'd0, two_lines_r};
      REG_LARGE_FONT:  cfg_prdata = {31'd0, large_font_r};
      REG_SHORT_HOLD:  cfg_prdata = {8'd0, short_hold_r};
      REG_LONG_HOLD:   cfg_prdata = {8'd0, long_hold_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.bus_width_8 = bus_width_8_r;
  assign cfg.two_lines   = two_lines_r;
  assign cfg.large_font  = large_font_r;
  assign cfg.short_hold  = short_hold_r;
  assign cfg.long_hold   = long_hold_r;

endmodule

// ===== rtl/lcdseq_ctrl.sv =====
// ---------------------------------------------------------------------------
// lcdseq_ctrl
// Step counter and microcode fetch; dispatches on the request kind.
// ---------------------------------------------------------------------------
`include "char_lcd_nibble_sequencer_macros.svh"

module lcdseq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic [1:0]            in_tuser,   // [1:0] kind
  output logic                  in_tready,
  input  logic                  room,
  output lcdseq_pkg::seq_ctl_t  ctl
);
  import lcdseq_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            busy_r, busy_nxt;
  ucode_t          word;

  assign in_tready  = ~busy_r;
  assign word       = ucode_rom(pc_r);
  assign ctl.accept = in_tvalid & ~busy_r;
  assign ctl.step   = busy_r & room;
  assign ctl.word   = word;

  // Dispatch on accept, advance one step per output transfer
  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (ctl.accept) begin
      busy_nxt = 1'b1;
      pc_nxt   = (kind_t'(in_tuser) == KIND_INIT) ? PC_INIT : PC_BYTE;
    end else if (ctl.step) begin
      if (word.last) begin
        busy_nxt = 1'b0;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= PC_INIT;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  `LCDSEQ_ASSERT_NEXT(a_accept_busy, ctl.accept, busy_r, "accepted request did not start")
  `LCDSEQ_ASSERT_NEXT(a_last_done, ctl.step && word.last, !busy_r, "program ran past last")
  `LCDSEQ_ASSERT_NOW(a_pc_range, busy_r, pc_r < PROG_LEN, "step counter out of program")
  `LCDSEQ_ASSERT_NEXT(a_pc_hold, busy_r && !ctl.step, $stable(pc_r), "step moved while stalled")

endmodule

// ===== rtl/lcdseq_datapath.sv =====
// ---------------------------------------------------------------------------
// lcdseq_datapath
// Request byte latch, nibble and hold selection, and the output register.
// ---------------------------------------------------------------------------
module lcdseq_datapath #(
  parameter int unsigned COLUMNS = lcdseq_pkg::COLUMNS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lcdseq_pkg::cfg_t      cfg,
  input  lcdseq_pkg::seq_ctl_t  ctl,
  input  logic [23:0]           in_tdata,   // [7:0] value, [9:8] row, [16:10] column
  input  logic [1:0]            in_tuser,   // [1:0] kind
  output logic                  room,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [0] enable, [4:1] nibble, [28:5] hold
  output logic                  out_tuser,  // [0] reg_select
  output logic                  out_tlast
);
  import lcdseq_pkg::*;

  localparam logic [127:0][7:0] OFF_TAB = off_table(COLUMNS);

  logic [7:0]  value;
  logic [1:0]  row;
  logic [6:0]  column;
  logic [7:0]  req_byte;
  logic [7:0]  req_byte_r;
  logic        rs_r;
  logic [7:0]  fset;
  logic [7:0]  src_byte;
  logic [3:0]  nib;
  logic [24:0] settle_sum;
  logic [23:0] settle;
  logic [23:0] hold;

  logic        out_valid_r;
  logic        en_r;
  logic [3:0]  nib_r;
  logic [23:0] hold_r;
  logic        rs_out_r;
  logic        last_r;

  assign value  = in_tdata[7:0];
  assign row    = in_tdata[9:8];
  assign column = in_tdata[16:10];

  // Byte for a single-byte request; cursor adds the wrapped column offset
  always_comb begin
    if (kind_t'(in_tuser) == KIND_CURSOR) begin
      req_byte = ((row == 2'd1) ? ROW1_BASE : ROW2_BASE) + OFF_TAB[column];
    end else begin
      req_byte = value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_byte_r <= req_byte;
      rs_r       <= (kind_t'(in_tuser) == KIND_CHAR);
    end
  end

  // Byte source and nibble select
  assign fset = {2'b00, 1'b1, cfg.bus_width_8, cfg.two_lines, cfg.large_font, 2'b00};

  always_comb begin
    case (ctl.word.bsel)
      BS_REQ:  src_byte = req_byte_r;
      BS_FSET: src_byte = fset;
      default: src_byte = ctl.word.imm;
    endcase
    case (ctl.word.nsel)
      NS_HI:   nib = src_byte[7:4];
      NS_LO:   nib = src_byte[3:0];
      default: nib = ctl.word.imm[3:0];
    endcase
  end

  // Hold select; clear settle saturates at full scale
  assign settle_sum = {1'b0, cfg.short_hold} + {1'b0, CLEAR_SETTLE};
  assign settle     = settle_sum[24] ? '1 : settle_sum[23:0];

  always_comb begin
    case (ctl.word.hsel)
      HS_LONG:   hold = cfg.long_hold;
      HS_SETTLE: hold = settle;
      default:   hold = cfg.short_hold;
    endcase
  end

  // Output register
  assign room = ~out_valid_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      en_r     <= ctl.word.en;
      nib_r    <= nib;
      hold_r   <= hold;
      rs_out_r <= (ctl.word.bsel == BS_REQ) ? rs_r : 1'b0;
      last_r   <= ctl.word.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, hold_r, nib_r, en_r};
  assign out_tuser  = rs_out_r;
  assign out_tlast  = last_r;

endmodule

// ===== rtl/char_lcd_nibble_sequencer.sv =====
// ---------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Character LCD 4-bit interface controller turning requests into pin phases.
// ---------------------------------------------------------------------------
// Each accepted request becomes a run of pin phases on the output stream:
// an init request gives 29 phases, a command, character or cursor request
// gives 4 (high nibble E-high, E-low, then low nibble). Each phase carries
// E, D4..D7 and a hold count in delay units; RS travels in out_tuser and
// out_tlast marks the final phase. A microcode step counter emits one phase
// per cycle while the output register is free; the request port is ready
// again as soon as the final phase is in the output register. Configuration
// (function-set bits, short and long hold) must be written over the APB port
// only while no request is in flight; the block itself does not enforce it.
// ---------------------------------------------------------------------------
module char_lcd_nibble_sequencer #(
  parameter int unsigned COLUMNS = lcdseq_pkg::COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [7:0] value, [9:8] row, [16:10] column
  input  logic [1:0]  in_tuser,    // [1:0] kind
  // phase stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [0] enable, [4:1] nibble, [28:5] hold
  output logic        out_tuser,   // [0] reg_select
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lcdseq_pkg::*;

  cfg_t     cfg;
  seq_ctl_t ctl;
  logic     room;

  lcdseq_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lcdseq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .room      (room),
    .ctl       (ctl)
  );

  lcdseq_datapath #(
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .ctl        (ctl),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer testbench
// Sends init, command, character and cursor requests and writes the
// function-set and hold registers over the APB port. Every pin phase that
// comes out is checked against a phase list worked out locally from the
// request and the register copy. Random gaps and stalls are applied on both
// streams.
// ----------------------------------------------------------------------------
module testbench;
  import lcdseq_pkg::*;

  // Init program contents
  localparam logic [3:0] WAKE_NIBBLE      = 4'h3;
  localparam logic [3:0] WAKE_LAST_NIBBLE = 4'h2;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h04;
  localparam logic [7:0] CMD_SHIFT        = 8'h10;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] FSET_BASE        = 8'h20;
  localparam logic [23:0] HOLD_MAX        = 24'hFFFFFF;
  localparam int unsigned MAX_PRINTED     = 40;
  localparam int unsigned RANDOM_PHASES   = 4;
  localparam int unsigned ITEMS_PER_PHASE = 48;

  typedef struct packed {
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    logic [23:0] hold;
    logic        last;
  } lcd_phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic [1:0] row;
    logic [6:0] column;
  } lcd_request_t;

  // Expected pin phases and the register copy that shapes them
  class lcd_phase_board;
    lcd_phase_t  phase_q[$];
    int unsigned errors;
    int unsigned phases_seen;
    logic        dl;
    logic        two_line;
    logic        font;
    logic [23:0] short_h;
    logic [23:0] long_h;

    function new();
      errors      = 0;
      phases_seen = 0;
      dl          = 1'b0;
      two_line    = 1'b1;
      font        = 1'b0;
      short_h     = SHORT_HOLD_RST;
      long_h      = LONG_HOLD_RST;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_BUS_WIDTH_8: dl       = val[0];
        REG_TWO_LINES:   two_line = val[0];
        REG_LARGE_FONT:  font     = val[0];
        REG_SHORT_HOLD:  short_h  = val[23:0];
        REG_LONG_HOLD:   long_h   = val[23:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return phase_q.size();
    endfunction

    function void push_phase(logic rs, logic en, logic [3:0] nib, logic [23:0] hold,
                             logic last);
      lcd_phase_t p;
      p.rs   = rs;
      p.en   = en;
      p.nib  = nib;
      p.hold = hold;
      p.last = last;
      phase_q.push_back(p);
    endfunction

    // E-high then E-low with the same nibble
    function void push_nibble(logic rs, logic [3:0] nib, logic [23:0] hi_hold,
                              logic [23:0] lo_hold, logic last);
      push_phase(rs, 1'b1, nib, hi_hold, 1'b0);
      push_phase(rs, 1'b0, nib, lo_hold, last);
    endfunction

    function void push_byte(logic rs, logic [7:0] b, logic [23:0] tail, logic last);
      push_nibble(rs, b[7:4], short_h, short_h, 1'b0);
      push_nibble(rs, b[3:0], short_h, tail, last);
    endfunction

    // Work out every phase caused by one accepted request
    function void note_request(lcd_request_t req);
      logic [24:0]  settle_sum;
      logic [23:0]  settle;
      logic [7:0]   fset;
      logic [7:0]   base;
      int unsigned  off;
      settle_sum = {1'b0, short_h} + {1'b0, CLEAR_SETTLE};
      settle     = settle_sum[24] ? HOLD_MAX : settle_sum[23:0];
      fset       = FSET_BASE | {3'b000, dl, two_line, font, 2'b00};
      case (req.kind)
        KIND_INIT: begin
          push_phase(1'b0, 1'b0, 4'h0, short_h, 1'b0);
          push_nibble(1'b0, WAKE_NIBBLE, short_h, short_h, 1'b0);
          push_nibble(1'b0, WAKE_NIBBLE, short_h, short_h, 1'b0);
          push_nibble(1'b0, WAKE_NIBBLE, short_h, short_h, 1'b0);
          push_nibble(1'b0, WAKE_LAST_NIBBLE, long_h, short_h, 1'b0);
          push_byte(1'b0, CMD_DISPLAY_ON, short_h, 1'b0);
          push_byte(1'b0, CMD_ENTRY_MODE, short_h, 1'b0);
          push_byte(1'b0, CMD_SHIFT, short_h, 1'b0);
          push_byte(1'b0, CMD_CLEAR, settle, 1'b0);
          push_byte(1'b0, fset, short_h, 1'b1);
        end
        KIND_CMD:  push_byte(1'b0, req.value, short_h, 1'b1);
        KIND_CHAR: push_byte(1'b1, req.value, short_h, 1'b1);
        default: begin
          // row 1 selects the first line, anything else the second
          base = (req.row == 2'd1) ? ROW1_BASE : ROW2_BASE;
          off  = (int'(req.column) + COLUMNS_DEF - 1) % COLUMNS_DEF;
          push_byte(1'b0, base + 8'(off), short_h, 1'b1);
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) begin
        $display("%0t phase %0d: %s", $time, phases_seen, msg);
      end
    endtask

    task check_phase(lcd_phase_t got);
      lcd_phase_t want;
      if (phase_q.size() == 0) begin
        report($sformatf("unexpected phase %h", got));
      end else begin
        want = phase_q.pop_front();
        if (got.rs !== want.rs)
          report($sformatf("reg_select %b, expected %b", got.rs, want.rs));
        if (got.en !== want.en)
          report($sformatf("enable %b, expected %b", got.en, want.en));
        if (got.nib !== want.nib)
          report($sformatf("nibble %h, expected %h", got.nib, want.nib));
        if (got.hold !== want.hold)
          report($sformatf("hold %0d, expected %0d", got.hold, want.hold));
        if (got.last !== want.last)
          report($sformatf("last %b, expected %b", got.last, want.last));
      end
      phases_seen++;
    endtask
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = '0;   // [7:0] value, [9:8] row, [16:10] column
  logic [1:0]  in_tuser    = '0;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;          // [0] enable, [4:1] nibble, [28:5] hold
  logic        out_tuser;          // [0] reg_select
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lcd_phase_board board;
  bit          idle_in       = 1'b1;
  bit          idle_out      = 1'b1;
  int unsigned stall_request = 0;

  char_lcd_nibble_sequencer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one request; valid stays high when the next follows without a gap
  task automatic send_request(input kind_t kind, input logic [7:0] value,
                              input logic [1:0] row, input logic [6:0] column);
    int unsigned  gap;
    lcd_request_t req;
    gap = idle_in ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.kind   = kind;
    req.value  = value;
    req.row    = row;
    req.column = column;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, column, row, value};
    do @(posedge clk); while (in_tready !== 1'b1);
    board.note_request(req);
  endtask

  task automatic send_random();
    int unsigned pick;
    kind_t       kind;
    pick = $urandom_range(0, 9);
    if (pick == 0)      kind = KIND_INIT;
    else if (pick <= 3) kind = KIND_CMD;
    else if (pick <= 6) kind = KIND_CHAR;
    else                kind = KIND_CURSOR;
    send_request(kind, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                 7'($urandom_range(0, 127)));
  endtask

  // Drop valid, then wait for every outstanding phase
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // APB write; psel stays high so writes can follow back to back
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    board.set_reg(idx, val);
  endtask

  task automatic write_config(input logic dl, input logic two, input logic font,
                              input logic [23:0] short_h, input logic [23:0] long_h);
    write_reg(REG_BUS_WIDTH_8, {31'd0, dl});
    write_reg(REG_TWO_LINES, {31'd0, two});
    write_reg(REG_LARGE_FONT, {31'd0, font});
    write_reg(REG_SHORT_HOLD, {8'd0, short_h});
    write_reg(REG_LONG_HOLD, {8'd0, long_h});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] pick_hold();
    case ($urandom_range(0, 3))
      0:       return 24'd1;
      1:       return HOLD_MAX;
      2:       return 24'($urandom_range(1, 24'hFFFFFF));
      default: return 24'($urandom_range(1, 100));
    endcase
  endfunction

  // Phase receiver: per-transfer stall, or a long hold-off on request
  initial begin
    int unsigned wait_cycles;
    lcd_phase_t  got;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (stall_request > 0) begin
        wait_cycles   = stall_request;
        stall_request = 0;
      end else begin
        wait_cycles = idle_out ? $urandom_range(0, 7) : 0;
      end
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      got.rs   = out_tuser;
      got.en   = out_tdata[0];
      got.nib  = out_tdata[4:1];
      got.hold = out_tdata[28:5];
      got.last = out_tlast;
      board.check_phase(got);
    end
  end

  // Stimulus
  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration; unused fields carry junk
    send_request(KIND_INIT, 8'hFF, 2'd3, 7'd127);
    send_request(KIND_CMD, 8'h00, 2'd1, 7'd1);
    send_request(KIND_CMD, 8'hFF, 2'd0, 7'd0);
    send_request(KIND_CHAR, 8'h00, 2'd3, 7'd127);
    send_request(KIND_CHAR, 8'hFF, 2'd2, 7'd64);
    send_request(KIND_CHAR, 8'h5A, 2'd1, 7'd1);
    // cursor: first column, last column, wrap past the width, odd rows
    send_request(KIND_CURSOR, 8'hFF, 2'd1, 7'd1);
    send_request(KIND_CURSOR, 8'h00, 2'd1, 7'd16);
    send_request(KIND_CURSOR, 8'h00, 2'd1, 7'd17);
    send_request(KIND_CURSOR, 8'h00, 2'd2, 7'd64);
    send_request(KIND_CURSOR, 8'h00, 2'd0, 7'd0);
    send_request(KIND_CURSOR, 8'h00, 2'd3, 7'd127);
    drain();

    // zero holds, all function-set bits flipped
    write_config(1'b1, 1'b0, 1'b1, 24'd0, 24'd0);
    send_request(KIND_INIT, 8'h00, 2'd0, 7'd0);
    send_request(KIND_CHAR, 8'hA5, 2'd1, 7'd1);
    drain();

    // clear settle saturates
    write_config(1'b0, 1'b1, 1'b1, HOLD_MAX, HOLD_MAX);
    send_request(KIND_INIT, 8'h00, 2'd0, 7'd0);
    send_request(KIND_CURSOR, 8'h00, 2'd2, 7'd1);
    drain();

    // clear settle lands exactly on the maximum
    write_config(1'b0, 1'b0, 1'b0, HOLD_MAX - CLEAR_SETTLE, 24'd1);
    send_request(KIND_INIT, 8'h00, 2'd0, 7'd0);
    send_request(KIND_CMD, 8'h3C, 2'd0, 7'd0);
    drain();

    write_config(1'b1, 1'b1, 1'b0, 24'd1, HOLD_MAX);
    send_request(KIND_INIT, 8'h00, 2'd0, 7'd0);
    send_request(KIND_CHAR, 8'h7F, 2'd0, 7'd0);
    drain();

    // random requests under several settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), pick_hold(), pick_hold());
      idle_in  = (p != 1);
      idle_out = (p != 1);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // long receiver hold-off while requests keep coming back to back
        if (p == 2 && i == 8) begin
          idle_in       = 1'b0;
          stall_request = 300;
        end
        if (p == 2 && i == 30) idle_in = 1'b1;
        send_random();
      end
      drain();
    end

    idle_in  = 1'b1;
    idle_out = 1'b1;
    drain();
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== char_lcd_nibble_sequencer.f =====
+incdir+rtl
rtl/lcdseq_pkg.sv
rtl/lcdseq_cfg.sv
rtl/lcdseq_ctrl.sv
rtl/lcdseq_datapath.sv
rtl/char_lcd_nibble_sequencer.sv
test/testbench.sv
